### src/sha256bs_pkg.sv
// Shared types, constants and helpers for the SHA-256 byte stream hasher.
// Depends on nothing; imported by the round unit and the top level.
package sha256bs_pkg;

   typedef logic [31:0] word_type;

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
      word_type e;
      word_type f;
      word_type g;
      word_type h;
   } vars_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_FINAL,
      ST_OUT
   } state_type;

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam word_type INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

### src/sha256bs_round.sv
// One SHA-256 round plus one step of the rolling message schedule.
// Depends on sha256bs_pkg; used once per cycle by the top-level sequencer.
module sha256bs_round (
   input  sha256bs_pkg::vars_type vars_cur,
   input  sha256bs_pkg::word_type w0,
   input  sha256bs_pkg::word_type w1,
   input  sha256bs_pkg::word_type w9,
   input  sha256bs_pkg::word_type w14,
   input  sha256bs_pkg::word_type k,
   output sha256bs_pkg::vars_type vars_nxt,
   output sha256bs_pkg::word_type w_new
);
   import sha256bs_pkg::*;

   word_type t1, t2, sig0, sig1;

   always_comb begin
      sig1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
      sig0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
      w_new = sig1 + w9 + sig0 + w0;
      t1 = vars_cur.h + (rotr(vars_cur.e, 6) ^ rotr(vars_cur.e, 11) ^ rotr(vars_cur.e, 25))
         + ((vars_cur.e & vars_cur.f) ^ (~vars_cur.e & vars_cur.g)) + k + w0;
      t2 = (rotr(vars_cur.a, 2) ^ rotr(vars_cur.a, 13) ^ rotr(vars_cur.a, 22))
         + ((vars_cur.a & vars_cur.b) ^ (vars_cur.a & vars_cur.c)
            ^ (vars_cur.b & vars_cur.c));
      vars_nxt.h = vars_cur.g;
      vars_nxt.g = vars_cur.f;
      vars_nxt.f = vars_cur.e;
      vars_nxt.e = vars_cur.d + t1;
      vars_nxt.d = vars_cur.c;
      vars_nxt.c = vars_cur.b;
      vars_nxt.b = vars_cur.a;
      vars_nxt.a = t1 + t2;
   end

endmodule

### src/sha256_byte_stream_hasher.sv
// SHA-256 byte stream hasher: top level with byte intake, padding, round sequencer and digest output.
// Depends on sha256bs_pkg and sha256bs_round.
//
//   channel | direction | tdata               | tuser          | tlast
//   req_    | in        | [7:0] data_byte     | [0] has_byte   | end_of_message
//   rsp_    | out       | [31:0] digest_word  | [2:0] word_index | last_word
//
// A byte transaction is accepted in ST_IDLE; a full 64-byte block then runs the 64 rounds
// and a fold into the hash words. At end of message padding bytes enter one per cycle
// until the block is full (up to 64), then the block is compressed; with 56 or more bytes
// held, a second block of 64 padding bytes comes after and is compressed in turn.
// 8 digest words then go out, one per accepted cycle. req_tready is low while a block is
// compressed and, after the end transaction, until the last digest word is taken.
// Synchronous reset returns to the initial hash values with an empty message.
module sha256_byte_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] has_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast
);
   import sha256bs_pkg::*;

   state_type    state_ff, state_in;
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  bits_ff, bits_in;
   logic [511:0] blk_ff, blk_in;
   vars_type     wv_ff, wv_in, wv_rnd;
   word_type     hash_ff [8];
   word_type     hash_in [8];
   logic [5:0]   rnd_ff, rnd_in;
   logic [2:0]   idx_ff, idx_in;
   logic         pend_end_ff, pend_end_in;
   logic         sent80_ff, sent80_in;
   logic         len_ok_ff, len_ok_in;
   logic         final_ff, final_in;
   logic         req_acc, push;
   logic [7:0]   push_byte, len_byte;
   word_type     w_new;
   vars_type     hash_vars;

   assign req_acc  = req_tvalid & req_tready;
   assign len_byte = bits_ff[{~fill_ff[2:0], 3'b000} +: 8];
   assign hash_vars = '{a: hash_ff[0], b: hash_ff[1], c: hash_ff[2], d: hash_ff[3],
                        e: hash_ff[4], f: hash_ff[5], g: hash_ff[6], h: hash_ff[7]};

   sha256bs_round u_round (
      .vars_cur (wv_ff),
      .w0       (blk_ff[511 -: 32]),
      .w1       (blk_ff[479 -: 32]),
      .w9       (blk_ff[223 -: 32]),
      .w14      (blk_ff[63 -: 32]),
      .k        (ROUND_K[rnd_ff]),
      .vars_nxt (wv_rnd),
      .w_new    (w_new)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_tuser[0] && fill_ff == 6'd63) state_in = ST_ROUND;
               else if (req_tlast) state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            if (fill_ff == 6'd63) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (rnd_ff == 6'd63) state_in = ST_FINAL;
         end
         ST_FINAL: begin
            if (!pend_end_ff) state_in = ST_IDLE;
            else if (final_ff) state_in = ST_OUT;
            else state_in = ST_PAD;
         end
         ST_OUT: begin
            if (rsp_tready && idx_ff == 3'd7) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      fill_in     = fill_ff;
      bits_in     = bits_ff;
      blk_in      = blk_ff;
      wv_in       = wv_ff;
      hash_in     = hash_ff;
      rnd_in      = rnd_ff;
      idx_in      = idx_ff;
      pend_end_in = pend_end_ff;
      sent80_in   = sent80_ff;
      len_ok_in   = len_ok_ff;
      final_in    = final_ff;
      push        = 1'b0;
      push_byte   = req_tdata;
      req_tready  = (state_ff == ST_IDLE);
      rsp_tvalid  = (state_ff == ST_OUT);
      rsp_tdata   = hash_ff[idx_ff];
      rsp_tuser   = idx_ff;
      rsp_tlast   = (idx_ff == 3'd7);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               pend_end_in = req_tlast;
               sent80_in   = 1'b0;
               len_ok_in   = 1'b0;
               final_in    = 1'b0;
               if (req_tuser[0]) begin
                  push    = 1'b1;
                  bits_in = bits_ff + 64'd8;
               end
            end
         end
         ST_PAD: begin
            push      = 1'b1;
            sent80_in = 1'b1;
            if (!sent80_ff) push_byte = PAD_MARK;
            else if (len_ok_ff && fill_ff >= 6'd56) push_byte = len_byte;
            else push_byte = 8'h00;
            // length fits only if the marker landed ahead of the length field
            if (!sent80_ff && fill_ff <= 6'd55) len_ok_in = 1'b1;
            if (fill_ff == 6'd63) begin
               final_in  = len_ok_ff;
               len_ok_in = 1'b1;
            end
         end
         ST_ROUND: begin
            wv_in  = wv_rnd;
            blk_in = {blk_ff[479:0], w_new};
            rnd_in = rnd_ff + 6'd1;
         end
         ST_FINAL: begin
            hash_in[0] = hash_ff[0] + wv_ff.a;
            hash_in[1] = hash_ff[1] + wv_ff.b;
            hash_in[2] = hash_ff[2] + wv_ff.c;
            hash_in[3] = hash_ff[3] + wv_ff.d;
            hash_in[4] = hash_ff[4] + wv_ff.e;
            hash_in[5] = hash_ff[5] + wv_ff.f;
            hash_in[6] = hash_ff[6] + wv_ff.g;
            hash_in[7] = hash_ff[7] + wv_ff.h;
            idx_in     = 3'd0;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  hash_in     = INIT_HASH;
                  fill_in     = 6'd0;
                  bits_in     = 64'd0;
                  pend_end_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
      if (push) begin
         blk_in  = {blk_ff[503:0], push_byte};
         fill_in = fill_ff + 6'd1;
         // block full: load working variables and start the rounds
         if (fill_ff == 6'd63) begin
            wv_in  = hash_vars;
            rnd_in = 6'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= 6'd0;
         bits_ff     <= 64'd0;
         hash_ff     <= INIT_HASH;
         rnd_ff      <= 6'd0;
         idx_ff      <= 3'd0;
         pend_end_ff <= 1'b0;
         sent80_ff   <= 1'b0;
         len_ok_ff   <= 1'b0;
         final_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         bits_ff     <= bits_in;
         hash_ff     <= hash_in;
         rnd_ff      <= rnd_in;
         idx_ff      <= idx_in;
         pend_end_ff <= pend_end_in;
         sent80_ff   <= sent80_in;
         len_ok_ff   <= len_ok_in;
         final_ff    <= final_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      wv_ff  <= wv_in;
   end

endmodule

### src/sha256bs_checker.sv
// Port-level checks for the SHA-256 byte stream hasher, bound to the top level.
// Depends only on the top-level ports.
module sha256bs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // hold a stalled digest word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled digest word changed");

   a_no_intake: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while digest is out");

   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tuser == $past(rsp_tuser) + 3'd1)
      else $error("digest words not in sequence");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tlast == (rsp_tuser == 3'd7))
      else $error("last word flag mismatch");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

endmodule

bind sha256_byte_stream_hasher sha256bs_checker u_sha256bs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
